// ----- design/i2cee_pkg.sv -----
// Package for the I2C EEPROM byte access master: beat and config types,
// bus phase codes, register indexes and reset values. No dependencies.
package i2cee_pkg;

   // counter width default and register reset values
   localparam int TickCounterBitsDefault = 16;
   localparam logic [9:0]  PhaseTicksReset  = 10'd50;
   localparam logic [15:0] SettleTicksReset = 16'd1000;

   // configuration register indexes
   localparam int CsrIndexBits = 1;
   localparam logic [CsrIndexBits-1:0] RegPhaseTicks  = 1'd0;
   localparam logic [CsrIndexBits-1:0] RegSettleTicks = 1'd1;

   // command kinds
   localparam logic KindWrite = 1'b0;
   localparam logic KindRead  = 1'b1;

   // byte constants
   localparam logic [7:0] DevWrMask = 8'hFE;
   localparam logic [7:0] DevRdBit  = 8'h01;
   localparam logic [7:0] MsbMask   = 8'h80;

   // bus phase codes
   localparam int PhaseBits = 5;
   localparam logic [PhaseBits-1:0] PhIdle   = 5'd0;
   localparam logic [PhaseBits-1:0] PhStHi   = 5'd1;
   localparam logic [PhaseBits-1:0] PhStLo   = 5'd2;
   localparam logic [PhaseBits-1:0] PhBitLo  = 5'd3;
   localparam logic [PhaseBits-1:0] PhBitHi  = 5'd4;
   localparam logic [PhaseBits-1:0] PhAckLo  = 5'd5;
   localparam logic [PhaseBits-1:0] PhAckHi  = 5'd6;
   localparam logic [PhaseBits-1:0] PhRsLo   = 5'd7;
   localparam logic [PhaseBits-1:0] PhRsHi   = 5'd8;
   localparam logic [PhaseBits-1:0] PhRsFall = 5'd9;
   localparam logic [PhaseBits-1:0] PhRdLo   = 5'd10;
   localparam logic [PhaseBits-1:0] PhRdHi   = 5'd11;
   localparam logic [PhaseBits-1:0] PhNkLo   = 5'd12;
   localparam logic [PhaseBits-1:0] PhNkHi   = 5'd13;
   localparam logic [PhaseBits-1:0] PhSpLo   = 5'd14;
   localparam logic [PhaseBits-1:0] PhSpHi   = 5'd15;
   localparam logic [PhaseBits-1:0] PhSpRel  = 5'd16;
   localparam logic [PhaseBits-1:0] PhSettle = 5'd17;
   localparam logic [PhaseBits-1:0] PhDone   = 5'd18;

   // byte numbers within a transaction
   localparam logic [1:0] ByteDev  = 2'd0;
   localparam logic [1:0] ByteAddr = 2'd1;
   localparam logic [1:0] ByteLast = 2'd2;

   typedef struct packed {
      logic       start_cmd;
      logic       kind;
      logic [7:0] device_addr;
      logic [8:0] mem_addr;
      logic [7:0] write_data;
      logic       sda_in;
   } i2cee_req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_result;
      logic       ack_error;
   } i2cee_rsp_type;

   typedef struct packed {
      logic [9:0]  phase_ticks;
      logic [15:0] settle_ticks;
   } i2cee_cfg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] device_addr;
      logic [8:0] mem_addr;
      logic [7:0] write_data;
   } i2cee_cmd_type;

endpackage

// ----- design/i2cee_seq.sv -----
// Bus sequencer: holds phase, tick counter, shifter and latched command,
// and advances them by one tick per accepted beat. Uses i2cee_pkg.
module i2cee_seq
   import i2cee_pkg::*;
#(
   parameter int TICK_COUNTER_BITS = TickCounterBitsDefault
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  i2cee_cfg_type cfg,
   input  i2cee_req_type req,
   output i2cee_rsp_type rsp
);

   localparam int HoldW = (TICK_COUNTER_BITS > 16) ? TICK_COUNTER_BITS : 16;
   localparam logic [TICK_COUNTER_BITS-1:0] CntMax = '1;

   logic [PhaseBits-1:0]         phase_ff, phase_in;
   logic [TICK_COUNTER_BITS-1:0] tick_ff, tick_in;
   logic [2:0]                   bit_ff, bit_in;
   logic [7:0]                   shift_ff, shift_in;
   logic [7:0]                   read_ff, read_in;
   i2cee_cmd_type                cmd_ff, cmd_in;
   logic                         nack_ff, nack_in;
   logic [1:0]                   byte_ff, byte_in;

   // effective state after a possible launch
   logic [PhaseBits-1:0]         ph;
   logic [TICK_COUNTER_BITS-1:0] tc, tc_inc, hold;
   logic [HoldW-1:0]             hold_w;
   logic                         last;
   logic [7:0]                   page, rd_shift;

   always_comb begin
      ph      = phase_ff;
      cmd_in  = cmd_ff;
      nack_in = nack_ff;
      tc      = tick_ff;
      bit_in  = bit_ff;
      byte_in = byte_ff;
      // launch only from idle
      if (phase_ff == PhIdle && req.start_cmd) begin
         cmd_in  = '{kind: req.kind, device_addr: req.device_addr,
                     mem_addr: req.mem_addr, write_data: req.write_data};
         nack_in = 1'b0;
         tc      = '0;
         bit_in  = 3'd0;
         byte_in = ByteDev;
         ph      = PhStHi;
      end

      page     = {6'd0, cmd_in.mem_addr[8], 1'b0};
      rd_shift = {shift_ff[6:0], req.sda_in};

      // line levels of the phase the tick begins in
      rsp.scl           = 1'b1;
      rsp.sda_drive_low = 1'b0;
      case (ph)
         PhStLo, PhRsFall, PhSpHi: rsp.sda_drive_low = 1'b1;
         PhBitLo: begin
            rsp.scl           = 1'b0;
            rsp.sda_drive_low = ((shift_ff & MsbMask) == 8'd0);
         end
         PhBitHi: rsp.sda_drive_low = ((shift_ff & MsbMask) == 8'd0);
         PhAckLo, PhRsLo, PhRdLo, PhNkLo: rsp.scl = 1'b0;
         PhSpLo: begin
            rsp.scl           = 1'b0;
            rsp.sda_drive_low = 1'b1;
         end
         default: ;
      endcase
      rsp.busy_res = (ph != PhIdle) && (ph != PhDone);
      rsp.done_res = (ph == PhDone);

      // phase hold, saturated to the counter range
      if (ph == PhSettle) hold_w = HoldW'(cfg.settle_ticks);
      else if (cfg.phase_ticks == 10'd0) hold_w = HoldW'(1);
      else hold_w = HoldW'(cfg.phase_ticks);
      hold   = (hold_w > HoldW'(CntMax)) ? CntMax : hold_w[TICK_COUNTER_BITS-1:0];
      tc_inc = tc + 1'b1;
      last   = (tc_inc >= hold) || (tc_inc == '0);

      phase_in = ph;
      tick_in  = tc;
      shift_in = shift_ff;
      read_in  = read_ff;

      // phase advance
      if (ph == PhDone) begin
         phase_in = PhIdle;
         tick_in  = '0;
      end else if (ph != PhIdle) begin
         tick_in = tc_inc;
         if (last) begin
            tick_in = '0;
            case (ph)
               PhStHi: phase_in = PhStLo;
               PhStLo: begin
                  shift_in = (cmd_in.device_addr & DevWrMask) | page;
                  bit_in   = 3'd0;
                  byte_in  = ByteDev;
                  phase_in = PhBitLo;
               end
               PhBitLo: phase_in = PhBitHi;
               PhBitHi: begin
                  if (bit_in == 3'd7) begin
                     bit_in   = 3'd0;
                     phase_in = PhAckLo;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     shift_in = {shift_ff[6:0], 1'b0};
                     phase_in = PhBitLo;
                  end
               end
               PhAckLo: phase_in = PhAckHi;
               PhAckHi: begin
                  if (req.sda_in) nack_in = 1'b1;
                  if (byte_in == ByteDev) begin
                     shift_in = cmd_in.mem_addr[7:0];
                     bit_in   = 3'd0;
                     byte_in  = ByteAddr;
                     phase_in = PhBitLo;
                  end else if (byte_in == ByteAddr) begin
                     if (cmd_in.kind == KindWrite) begin
                        shift_in = cmd_in.write_data;
                        bit_in   = 3'd0;
                        byte_in  = ByteLast;
                        phase_in = PhBitLo;
                     end else begin
                        phase_in = PhRsLo;
                     end
                  end else begin
                     bit_in   = 3'd0;
                     phase_in = (cmd_in.kind == KindWrite) ? PhSpLo : PhRdLo;
                  end
               end
               PhRsLo:   phase_in = PhRsHi;
               PhRsHi:   phase_in = PhRsFall;
               PhRsFall: begin
                  shift_in = cmd_in.device_addr | DevRdBit | page;
                  bit_in   = 3'd0;
                  byte_in  = ByteLast;
                  phase_in = PhBitLo;
               end
               PhRdLo: phase_in = PhRdHi;
               PhRdHi: begin
                  shift_in = rd_shift;
                  if (bit_in == 3'd7) begin
                     bit_in   = 3'd0;
                     read_in  = rd_shift;
                     phase_in = PhNkLo;
                  end else begin
                     bit_in   = bit_in + 3'd1;
                     phase_in = PhRdLo;
                  end
               end
               PhNkLo:   phase_in = PhNkHi;
               PhNkHi:   phase_in = PhSpLo;
               PhSpLo:   phase_in = PhSpHi;
               PhSpHi:   phase_in = PhSpRel;
               PhSpRel:  phase_in = (cfg.settle_ticks == 16'd0) ? PhDone : PhSettle;
               PhSettle: phase_in = PhDone;
               default:  phase_in = PhIdle;
            endcase
         end
      end

      rsp.read_result = read_in;
      rsp.ack_error   = nack_in;
   end

   // state registers, stepped once per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhIdle;
         tick_ff  <= '0;
         bit_ff   <= 3'd0;
         shift_ff <= 8'd0;
         read_ff  <= 8'd0;
         cmd_ff   <= '0;
         nack_ff  <= 1'b0;
         byte_ff  <= ByteDev;
      end else if (step) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         read_ff  <= read_in;
         cmd_ff   <= cmd_in;
         nack_ff  <= nack_in;
         byte_ff  <= byte_in;
      end
   end

endmodule

// ----- design/i2c_eeprom_byte_access_master.sv -----
// Top level of the I2C EEPROM byte access master: config registers,
// beat handshake and result register. Uses i2cee_pkg and i2cee_seq.
//
// Each request beat is one tick of the I2C bus sequencer: it carries the
// command fields and the sampled SDA level, and yields exactly one response
// beat with the SCL/SDA drive levels, busy/done flags, the last read byte and
// the ack error flag. A beat is taken every clock cycle unless req_stall is
// high; the sequencer steps once per beat and the response is registered,
// so it appears in the cycle after its request is taken. The response
// register lets a new request in while the previous response is still held,
// so req_stall only rises when the response is held and rsp_stall is high.
// A single-byte write sends start, device, address and data bytes with acks
// and stop, a read more phases; phase_ticks sets each phase, settle_ticks
// the idle time after stop. Write registers only while no beat is in flight;
// a new hold applies at once, also within a running phase.
module i2c_eeprom_byte_access_master
   import i2cee_pkg::*;
#(
   parameter int TICK_COUNTER_BITS = TickCounterBitsDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2cee_req_type           req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2cee_rsp_type           rsp_data,
   input  logic                    csr_write_enable,
   input  logic [CsrIndexBits-1:0] csr_index,
   input  logic [15:0]             csr_wdata
);

   i2cee_cfg_type cfg_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   i2cee_rsp_type rsp_data_ff;
   i2cee_rsp_type seq_rsp;
   logic          accept;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_ticks  <= PhaseTicksReset;
         cfg_ff.settle_ticks <= SettleTicksReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegPhaseTicks:  cfg_ff.phase_ticks  <= csr_wdata[9:0];
            RegSettleTicks: cfg_ff.settle_ticks <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake: stall only when the held response cannot leave
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   i2cee_seq #(
      .TICK_COUNTER_BITS(TICK_COUNTER_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (accept),
      .cfg   (cfg_ff),
      .req   (req_data),
      .rsp   (seq_rsp)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= seq_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
